// ===== src/lmts_pkg.sv =====
// Package for the display timing and status block: item and result types,
// mode and kind codes, register offsets and dot counts.
// No dependencies; used by lmts_engine, lcd_mode_timing_and_stat and the testbench.
package lmts_pkg;

	// Request kinds
	localparam logic [1:0] KIND_ADVANCE = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// Display modes held in status bits 1..0
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	// Register offsets from the base of the register window
	localparam logic [3:0] REG_CONTROL  = 4'd0;
	localparam logic [3:0] REG_STATUS   = 4'd1;
	localparam logic [3:0] REG_SCROLL_Y = 4'd2;
	localparam logic [3:0] REG_SCROLL_X = 4'd3;
	localparam logic [3:0] REG_LINE     = 4'd4;
	localparam logic [3:0] REG_COMPARE  = 4'd5;
	localparam logic [3:0] REG_BG_PAL   = 4'd7;
	localparam logic [3:0] REG_OBJ_PAL0 = 4'd8;
	localparam logic [3:0] REG_OBJ_PAL1 = 4'd9;
	localparam logic [3:0] REG_WIN_Y    = 4'd10;
	localparam logic [3:0] REG_WIN_X    = 4'd11;

	// Dot counts per mode and line limits
	localparam logic [15:0] SCAN_DOTS   = 16'd80;
	localparam logic [15:0] DRAW_DOTS   = 16'd172;
	localparam logic [15:0] HBLANK_DOTS = 16'd204;
	localparam logic [15:0] LINE_DOTS   = 16'd456;
	localparam logic [7:0]  VBLANK_LINE = 8'd144;
	localparam logic [7:0]  LAST_LINE   = 8'd153;

	localparam logic [7:0] STAT_WRITE_MASK = 8'hF8;
	localparam logic [7:0] CONTROL_RESET   = 8'h90;
	localparam logic [7:0] BG_PAL_RESET    = 8'hFC;
	localparam logic [7:0] OBJ_PAL_RESET   = 8'hFF;
	localparam logic [7:0] READ_IDLE       = 8'hFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] dot_delta;
		logic [3:0] reg_offset;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] line_now;
		logic [1:0] mode_now;
		logic       bad_register;
		logic       frame_done;
		logic       line_done;
		logic       vblank_interrupt;
		logic       lcd_interrupt;
		logic [7:0] read_data;
	} result_t;

endpackage

// ===== src/lmts_engine.sv =====
// Register file, dot accumulator and mode sequencer of the display timing block.
// Holds all architectural state and computes one request's result combinationally.
// Depends on lmts_pkg.
module lmts_engine import lmts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t result
);

	logic [15:0] accum_q, accum_n;
	logic [7:0]  line_q, line_n;
	logic [7:0]  control_q, control_n;
	logic [7:0]  status_q, status_n;
	logic [7:0]  compare_q, compare_n;
	logic [7:0]  scroll_y_q, scroll_y_n;
	logic [7:0]  scroll_x_q, scroll_x_n;
	logic [7:0]  bg_pal_q, bg_pal_n;
	logic [7:0]  obj_pal0_q, obj_pal0_n;
	logic [7:0]  obj_pal1_q, obj_pal1_n;
	logic [7:0]  win_y_q, win_y_n;
	logic [7:0]  win_x_q, win_x_n;
	logic        level_q, level_n;

	logic [16:0] sum;
	logic [15:0] acc_sat;
	logic [7:0]  line_inc;
	logic [1:0]  mode;
	logic        same;
	logic        cond;

	assign sum      = {1'b0, accum_q} + {9'd0, item.dot_delta};
	assign acc_sat  = sum[16] ? 16'hFFFF : sum[15:0];
	assign line_inc = line_q + 8'd1;
	assign mode     = status_q[1:0];
	assign same     = (line_q == compare_q);
	assign cond     = (same && status_q[6]) ||
	                  (mode == MODE_HBLANK && status_q[3]) ||
	                  (mode == MODE_SCAN && status_q[5]) ||
	                  (mode == MODE_VBLANK && (status_q[4] || status_q[5]));

	always_comb begin
		accum_n    = accum_q;
		line_n     = line_q;
		control_n  = control_q;
		status_n   = status_q;
		compare_n  = compare_q;
		scroll_y_n = scroll_y_q;
		scroll_x_n = scroll_x_q;
		bg_pal_n   = bg_pal_q;
		obj_pal0_n = obj_pal0_q;
		obj_pal1_n = obj_pal1_q;
		win_y_n    = win_y_q;
		win_x_n    = win_x_q;
		level_n    = level_q;
		result     = '0;
		result.read_data = READ_IDLE;

		case (item.kind)
			KIND_ADVANCE: begin
				accum_n = acc_sat;
				if (!control_q[7]) begin
					accum_n       = '0;
					line_n        = '0;
					status_n[1:0] = MODE_HBLANK;
				end else begin
					status_n[2]          = same;
					result.lcd_interrupt = cond && !level_q;
					level_n              = cond;
					case (mode)
						MODE_SCAN: begin
							if (acc_sat >= SCAN_DOTS) begin
								accum_n       = acc_sat - SCAN_DOTS;
								status_n[1:0] = MODE_DRAW;
							end
						end
						MODE_DRAW: begin
							if (acc_sat >= DRAW_DOTS) begin
								accum_n          = acc_sat - DRAW_DOTS;
								result.line_done = 1'b1;
								status_n[1:0]    = MODE_HBLANK;
							end
						end
						MODE_HBLANK: begin
							if (acc_sat >= HBLANK_DOTS) begin
								accum_n = acc_sat - HBLANK_DOTS;
								line_n  = line_inc;
								if (line_inc == VBLANK_LINE) begin
									status_n[1:0]           = MODE_VBLANK;
									result.vblank_interrupt = 1'b1;
									result.frame_done       = 1'b1;
								end else begin
									status_n[1:0] = MODE_SCAN;
								end
							end
						end
						default: begin
							if (acc_sat >= LINE_DOTS) begin
								accum_n = acc_sat - LINE_DOTS;
								line_n  = line_inc;
								// A counter that wrapped to zero stays in vertical blank.
								if (line_inc > LAST_LINE) begin
									status_n[1:0] = MODE_SCAN;
									line_n        = '0;
								end
							end
						end
					endcase
				end
			end
			KIND_WRITE: begin
				case (item.reg_offset)
					REG_CONTROL:  control_n  = item.write_data;
					REG_STATUS:   status_n   = (status_q & ~STAT_WRITE_MASK) |
					                           (item.write_data & STAT_WRITE_MASK);
					REG_SCROLL_Y: scroll_y_n = item.write_data;
					REG_SCROLL_X: scroll_x_n = item.write_data;
					REG_LINE:     line_n     = item.write_data;
					REG_COMPARE:  compare_n  = item.write_data;
					REG_BG_PAL:   bg_pal_n   = item.write_data;
					REG_OBJ_PAL0: obj_pal0_n = item.write_data;
					REG_OBJ_PAL1: obj_pal1_n = item.write_data;
					REG_WIN_Y:    win_y_n    = item.write_data;
					REG_WIN_X:    win_x_n    = item.write_data;
					default:      result.bad_register = 1'b1;
				endcase
			end
			KIND_READ: begin
				case (item.reg_offset)
					REG_CONTROL:  result.read_data = control_q;
					REG_STATUS:   result.read_data = status_q;
					REG_SCROLL_Y: result.read_data = scroll_y_q;
					REG_SCROLL_X: result.read_data = scroll_x_q;
					REG_LINE:     result.read_data = line_q;
					REG_COMPARE:  result.read_data = compare_q;
					REG_BG_PAL:   result.read_data = bg_pal_q;
					REG_OBJ_PAL0: result.read_data = obj_pal0_q;
					REG_OBJ_PAL1: result.read_data = obj_pal1_q;
					REG_WIN_Y:    result.read_data = win_y_q;
					REG_WIN_X:    result.read_data = win_x_q;
					default:      result.bad_register = 1'b1;
				endcase
			end
			default: begin
			end
		endcase

		result.mode_now = status_n[1:0];
		result.line_now = line_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			line_q     <= '0;
			control_q  <= CONTROL_RESET;
			status_q   <= '0;
			compare_q  <= '0;
			scroll_y_q <= '0;
			scroll_x_q <= '0;
			bg_pal_q   <= BG_PAL_RESET;
			obj_pal0_q <= OBJ_PAL_RESET;
			obj_pal1_q <= OBJ_PAL_RESET;
			win_y_q    <= '0;
			win_x_q    <= '0;
			level_q    <= 1'b0;
		end else if (fire) begin
			accum_q    <= accum_n;
			line_q     <= line_n;
			control_q  <= control_n;
			status_q   <= status_n;
			compare_q  <= compare_n;
			scroll_y_q <= scroll_y_n;
			scroll_x_q <= scroll_x_n;
			bg_pal_q   <= bg_pal_n;
			obj_pal0_q <= obj_pal0_n;
			obj_pal1_q <= obj_pal1_n;
			win_y_q    <= win_y_n;
			win_x_q    <= win_x_n;
			level_q    <= level_n;
		end
	end

endmodule

// ===== src/lcd_mode_timing_and_stat.sv =====
// Top level of the display timing and status block: input register, engine and
// result register with stream handshakes. Depends on lmts_pkg and lmts_engine.
//
// Usage. Requests arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser).
// s_tuser carries the request kind: advance the dot clock, write a register or
// read a register. Every request produces exactly one result on the master
// stream (m_tvalid, m_tready, m_tdata), carrying the read data, the interrupt
// and line/frame strobes, an unknown-offset flag and the mode and line after
// the request.
// Flow: an accepted request is held in the input register, processed by the
// engine once the result register is free or being emptied, and then lands in
// the result register, which raises m_tvalid.
// Throughput: one request per clock while m_tready is high. The engine's update
// of accumulator, mode and register file is the only logic between the registers.
// When the receiver stalls, the pending result is held and the input register
// still takes one further request; after that s_tready falls until the result
// is taken, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties both registers and restores the
// register file to its power-on values: control 0x90, background palette 0xFC,
// object palettes 0xFF and everything else zero, with the display in mode 0.
module lcd_mode_timing_and_stat import lmts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] dot_delta, [11:8] reg_offset, [19:12] write_data, [23:20] zero
	input  logic [23:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_data, [8] lcd_interrupt, [9] vblank_interrupt, [10] line_done,
	// [11] frame_done, [12] bad_register, [14:13] mode_now, [22:15] line_now,
	// [23] zero
	output logic [23:0] m_tdata
);

	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t out_q;
	logic    out_valid_q;
	logic    fire;

	// The engine may retire the held request when the result register is free
	// or being emptied in this cycle.
	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind       <= s_tuser;
			item_s1.dot_delta  <= s_tdata[7:0];
			item_s1.reg_offset <= s_tdata[11:8];
			item_s1.write_data <= s_tdata[19:12];
		end
	end

	lmts_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	// The frame strobe always accompanies the vertical blank interrupt.
	a_frame_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.frame_done == out_q.vblank_interrupt))
		else $error("frame_done differs from vblank_interrupt");

	// Entering vertical blank always lands on the first blank line in mode 1.
	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.vblank_interrupt) |->
		(out_q.mode_now == MODE_VBLANK && out_q.line_now == VBLANK_LINE))
		else $error("vblank entry with wrong mode or line");

	// The end of drawing always leaves the display in horizontal blank.
	a_line_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.line_done) |-> (out_q.mode_now == MODE_HBLANK))
		else $error("line_done without hblank");

	// An access to an unknown register offset never carries timing strobes.
	a_bad_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad_register) |->
		!(out_q.lcd_interrupt || out_q.vblank_interrupt || out_q.line_done))
		else $error("timing strobe on a register access");

endmodule

// ===== tb/tb_lcd_mode_timing_and_stat.sv =====
// Self-checking testbench for lcd_mode_timing_and_stat: random and directed requests
// on the slave stream, with results predicted and compared by a small scoreboard class.
// Depends on lmts_pkg for the request and result types, codes and dot counts.
`timescale 1ns / 1ps

module tb_lcd_mode_timing_and_stat;
	import lmts_pkg::*;

	// Request kind that the block must ignore, and register offsets with nothing behind them.
	localparam logic [1:0] KIND_NONE     = 2'd3;
	localparam logic [3:0] REG_UNUSED    = 4'd6;
	localparam logic [3:0] REG_FREE_LOW  = 4'd12;
	localparam logic [3:0] REG_FREE_HIGH = 4'd15;
	// Display enable bit of the control register.
	localparam logic [7:0] CTRL_ENABLE   = 8'h80;

	localparam int RANDOM_ITEMS  = 1050;
	localparam int TAIL_ITEMS    = 150;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED   = 50;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	// Scoreboard: keeps its own copy of the timing state and register file, works out
	// the result of every accepted request and compares results as they come out.
	class mode_timing_board;
		logic [15:0] dots;
		logic [7:0]  line_cnt;
		logic [7:0]  control;
		logic [7:0]  status;
		logic [7:0]  compare;
		logic [7:0]  scroll_y;
		logic [7:0]  scroll_x;
		logic [7:0]  bg_pal;
		logic [7:0]  obj_pal0;
		logic [7:0]  obj_pal1;
		logic [7:0]  win_y;
		logic [7:0]  win_x;
		logic        stat_level;
		result_t     due_results[$];
		int          errors;
		int          checked;

		function new();
			dots       = '0;
			line_cnt   = '0;
			control    = CONTROL_RESET;
			status     = '0;
			compare    = '0;
			scroll_y   = '0;
			scroll_x   = '0;
			bg_pal     = BG_PAL_RESET;
			obj_pal0   = OBJ_PAL_RESET;
			obj_pal1   = OBJ_PAL_RESET;
			win_y      = '0;
			win_x      = '0;
			stat_level = 1'b0;
			errors     = 0;
			checked    = 0;
		endfunction

		// Printing stops after a while so that a broken block cannot flood the log,
		// but every mismatch is still counted.
		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("MISMATCH: %s", msg);
		endtask

		// One request through the timing engine: returns the result it should give.
		function result_t step_timing(item_t req);
			result_t     r;
			logic [16:0] sum;
			logic        same;
			logic        cond;
			r = '0;
			r.read_data = READ_IDLE;
			case (req.kind)
			KIND_ADVANCE: begin
				sum = {1'b0, dots} + {9'd0, req.dot_delta};
				dots = sum[16] ? 16'hFFFF : sum[15:0];
				if (!control[7]) begin
					// Display off: everything timing related is held at zero.
					dots = '0;
					line_cnt = '0;
					status[1:0] = MODE_HBLANK;
				end else begin
					// STAT sources are judged on the mode before any step.
					same = (line_cnt == compare);
					cond = (same && status[6]) ||
						(status[1:0] == MODE_HBLANK && status[3]) ||
						(status[1:0] == MODE_SCAN && status[5]) ||
						(status[1:0] == MODE_VBLANK && (status[4] || status[5]));
					status[2] = same;
					r.lcd_interrupt = cond && !stat_level;
					stat_level = cond;
					case (status[1:0])
					MODE_SCAN: begin
						if (dots >= SCAN_DOTS) begin
							dots = dots - SCAN_DOTS;
							status[1:0] = MODE_DRAW;
						end
					end
					MODE_DRAW: begin
						if (dots >= DRAW_DOTS) begin
							dots = dots - DRAW_DOTS;
							r.line_done = 1'b1;
							status[1:0] = MODE_HBLANK;
						end
					end
					MODE_HBLANK: begin
						if (dots >= HBLANK_DOTS) begin
							dots = dots - HBLANK_DOTS;
							line_cnt = line_cnt + 8'd1;
							if (line_cnt == VBLANK_LINE) begin
								status[1:0] = MODE_VBLANK;
								r.vblank_interrupt = 1'b1;
								r.frame_done = 1'b1;
							end else begin
								status[1:0] = MODE_SCAN;
							end
						end
					end
					default: begin
						// A line counter that wrapped to zero stays in vblank.
						if (dots >= LINE_DOTS) begin
							dots = dots - LINE_DOTS;
							line_cnt = line_cnt + 8'd1;
							if (line_cnt > LAST_LINE) begin
								status[1:0] = MODE_SCAN;
								line_cnt = '0;
							end
						end
					end
					endcase
				end
			end
			KIND_WRITE: begin
				case (req.reg_offset)
				REG_CONTROL:  control = req.write_data;
				REG_STATUS:   status = (status & ~STAT_WRITE_MASK) |
					(req.write_data & STAT_WRITE_MASK);
				REG_SCROLL_Y: scroll_y = req.write_data;
				REG_SCROLL_X: scroll_x = req.write_data;
				REG_LINE:     line_cnt = req.write_data;
				REG_COMPARE:  compare = req.write_data;
				REG_BG_PAL:   bg_pal = req.write_data;
				REG_OBJ_PAL0: obj_pal0 = req.write_data;
				REG_OBJ_PAL1: obj_pal1 = req.write_data;
				REG_WIN_Y:    win_y = req.write_data;
				REG_WIN_X:    win_x = req.write_data;
				default:      r.bad_register = 1'b1;
				endcase
			end
			KIND_READ: begin
				case (req.reg_offset)
				REG_CONTROL:  r.read_data = control;
				REG_STATUS:   r.read_data = status;
				REG_SCROLL_Y: r.read_data = scroll_y;
				REG_SCROLL_X: r.read_data = scroll_x;
				REG_LINE:     r.read_data = line_cnt;
				REG_COMPARE:  r.read_data = compare;
				REG_BG_PAL:   r.read_data = bg_pal;
				REG_OBJ_PAL0: r.read_data = obj_pal0;
				REG_OBJ_PAL1: r.read_data = obj_pal1;
				REG_WIN_Y:    r.read_data = win_y;
				REG_WIN_X:    r.read_data = win_x;
				default:      r.bad_register = 1'b1;
				endcase
			end
			default: ;
			endcase
			r.mode_now = status[1:0];
			r.line_now = line_cnt;
			return r;
		endfunction

		function void note_request(item_t req);
			due_results.push_back(step_timing(req));
		endfunction

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
					checked, name, got, want));
		endtask

		task check_result(logic [23:0] bus);
			result_t got;
			result_t want;
			// The result fields sit in the low 23 bits in the order of result_t.
			got = result_t'(bus[22:0]);
			checked++;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %0d (%h) arrived with nothing expected",
					checked, bus));
				return;
			end
			want = due_results.pop_front();
			compare_field("read_data", got.read_data, want.read_data);
			compare_field("lcd_interrupt", got.lcd_interrupt, want.lcd_interrupt);
			compare_field("vblank_interrupt", got.vblank_interrupt, want.vblank_interrupt);
			compare_field("line_done", got.line_done, want.line_done);
			compare_field("frame_done", got.frame_done, want.frame_done);
			compare_field("bad_register", got.bad_register, want.bad_register);
			compare_field("mode_now", got.mode_now, want.mode_now);
			compare_field("line_now", got.line_now, want.line_now);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [7:0] dot_delta, [11:8] reg_offset, [19:12] write_data, [23:20] zero
	logic [23:0] s_tdata;
	// [1:0] kind
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [7:0] read_data, [8] lcd_interrupt, [9] vblank_interrupt, [10] line_done,
	// [11] frame_done, [12] bad_register, [14:13] mode_now, [22:15] line_now, [23] zero
	logic [23:0] m_tdata;

	mode_timing_board board;
	int sent;          // requests of a real kind accepted so far
	int gap_odds;      // one sender gap in this many requests; zero for none
	bit quiet_tail;    // no idling on either side from here on
	bit long_hold_done;

	lcd_mode_timing_and_stat i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Results are taken at the edge where valid and ready were both high before it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// Receiver. Ready drops in bursts during busy windows and stays high in calm ones.
	// Once, early on, it holds off for a long stretch so the block fills up and has to
	// push back on the sender.
	initial begin : receiver
		int window;
		int odds;
		window = 0;
		odds = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (window == 0) begin
				window = 64;
				odds = ($urandom_range(0, 2) == 0) ? 0 : 5;
			end
			window--;
			if (!long_hold_done && board.checked >= 150) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet_tail && odds != 0 && $urandom_range(1, odds) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Drops valid for a burst of cycles now and then, before the next request goes out.
	task automatic sender_gap();
		if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Offers one request and returns at the edge where it is accepted; valid stays high
	// so that the next request can follow without a gap.
	task automatic send_item(input logic [1:0] kind, input logic [7:0] delta,
		input logic [3:0] offset, input logic [7:0] wdata);
		item_t req;
		req.kind = kind;
		req.dot_delta = delta;
		req.reg_offset = offset;
		req.write_data = wdata;
		sender_gap();
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'h0, wdata, offset, delta};
		do @(posedge clk); while (!s_tready);
		board.note_request(req);
		if (kind != KIND_NONE)
			sent++;
	endtask

	// Sender stops offering until every outstanding result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.due_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [3:0] any_offset();
		return 4'($urandom_range(0, 15));
	endfunction

	// Dot steps lean towards the top end so that lines and frames go by quickly.
	function automatic logic [7:0] pick_delta();
		case ($urandom_range(0, 7))
		0:       return 8'h00;
		1, 2:    return 8'hFF;
		default: return any_byte();
		endcase
	endfunction

	// Most bursts that need a running display switch it back on if it is off.
	task automatic wake_display();
		if (!board.control[7] && $urandom_range(0, 3) != 0)
			send_item(KIND_WRITE, any_byte(), REG_CONTROL, any_byte() | CTRL_ENABLE);
	endtask

	task automatic directed_checks();
		// Power-on values of the register file.
		send_item(KIND_READ, 8'h00, REG_CONTROL, 8'h00);
		send_item(KIND_READ, 8'hFF, REG_STATUS, 8'hFF);
		send_item(KIND_READ, 8'h00, REG_BG_PAL, 8'h00);
		send_item(KIND_READ, 8'h00, REG_OBJ_PAL1, 8'h00);
		// The unused kind with every field at its top must change nothing.
		send_item(KIND_NONE, 8'hFF, REG_FREE_HIGH, 8'hFF);
		// Unknown offsets: the write is dropped, the read gives all ones.
		send_item(KIND_WRITE, 8'h00, REG_UNUSED, 8'hFF);
		send_item(KIND_READ, 8'h00, REG_FREE_HIGH, 8'h00);
		// Zero-dot advance sets the coincidence bit; then every STAT source is enabled,
		// so the next advance raises the interrupt while the following one does not.
		send_item(KIND_ADVANCE, 8'h00, REG_CONTROL, 8'h00);
		send_item(KIND_WRITE, 8'h00, REG_STATUS, 8'hFF);
		send_item(KIND_ADVANCE, 8'hFF, REG_CONTROL, 8'h00);
		send_item(KIND_ADVANCE, 8'hFF, REG_CONTROL, 8'h00);
		// Jump to the last visible line and run on into vblank.
		send_item(KIND_WRITE, 8'h00, REG_LINE, VBLANK_LINE - 8'd1);
		repeat (4) send_item(KIND_ADVANCE, 8'hFF, REG_CONTROL, 8'h00);
		// In vblank, a line counter that wraps past 255 stays in vblank ...
		send_item(KIND_WRITE, 8'h00, REG_LINE, 8'hFF);
		repeat (2) send_item(KIND_ADVANCE, 8'hFF, REG_CONTROL, 8'h00);
		// ... while one that passes the last line restarts the frame in scan mode.
		send_item(KIND_WRITE, 8'h00, REG_LINE, LAST_LINE + 8'd47);
		repeat (2) send_item(KIND_ADVANCE, 8'hFF, REG_CONTROL, 8'h00);
		// Display off zeroes the timing; then it is switched back on.
		send_item(KIND_WRITE, 8'h00, REG_CONTROL, 8'h00);
		send_item(KIND_ADVANCE, 8'h11, REG_CONTROL, 8'h00);
		send_item(KIND_WRITE, 8'h00, REG_CONTROL, CONTROL_RESET | 8'h01);
	endtask

	task automatic run_burst();
		int n;
		n = $urandom_range(4, 40);
		wake_display();
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				send_item(KIND_READ, any_byte(), any_offset(), any_byte());
			else
				send_item(KIND_ADVANCE, pick_delta(), any_offset(), any_byte());
		end
	endtask

	task automatic register_burst();
		int n;
		logic [3:0] offset;
		logic [7:0] wdata;
		n = $urandom_range(2, 10);
		repeat (n) begin
			offset = any_offset();
			wdata = any_byte();
			// Control writes mostly keep the display running.
			if (offset == REG_CONTROL && $urandom_range(0, 3) != 0)
				wdata = wdata | CTRL_ENABLE;
			if ($urandom_range(0, 1) == 0)
				send_item(KIND_WRITE, any_byte(), offset, wdata);
			else
				send_item(KIND_READ, any_byte(), offset, wdata);
		end
	endtask

	// Moves the line counter next to a boundary, often with a matching compare value
	// and fresh STAT enables, then runs the dot clock hard across it.
	task automatic line_jump_burst();
		logic [7:0] target;
		wake_display();
		if (board.status[1:0] == MODE_VBLANK) begin
			case ($urandom_range(0, 2))
			0:       target = 8'hFF;
			1:       target = LAST_LINE;
			default: target = 8'($urandom_range(154, 254));
			endcase
		end else begin
			case ($urandom_range(0, 3))
			0:       target = VBLANK_LINE - 8'd1;
			1:       target = VBLANK_LINE - 8'd2;
			2:       target = 8'hFF;
			default: target = any_byte();
			endcase
		end
		send_item(KIND_WRITE, any_byte(), REG_LINE, target);
		if ($urandom_range(0, 1) == 0)
			send_item(KIND_WRITE, any_byte(), REG_COMPARE, target + 8'($urandom_range(0, 2)));
		if ($urandom_range(0, 1) == 0)
			send_item(KIND_WRITE, any_byte(), REG_STATUS, any_byte());
		repeat ($urandom_range(6, 24))
			send_item(KIND_ADVANCE, 8'($urandom_range(120, 255)), any_offset(), any_byte());
	endtask

	// Anything at all, the unused kind and the unknown offsets included.
	task automatic noise_burst();
		repeat ($urandom_range(3, 12)) begin
			if ($urandom_range(0, 3) == 0)
				send_item(2'($urandom_range(1, 2)), any_byte(),
					4'($urandom_range(REG_FREE_LOW, REG_FREE_HIGH)), any_byte());
			else
				send_item(2'($urandom_range(0, 3)), any_byte(), any_offset(), any_byte());
		end
	endtask

	// Full-size steps gain on the accumulator outside vblank, so a long run of them
	// eventually pins it at the top. Once it is close, a few more steps are certain to
	// hit the clamp; then the display is switched off to clear it again.
	task automatic flood_to_saturation();
		int guard;
		guard = 0;
		send_item(KIND_WRITE, any_byte(), REG_CONTROL, any_byte() | CTRL_ENABLE);
		send_item(KIND_WRITE, any_byte(), REG_STATUS, any_byte());
		while (board.dots <= 16'hFF00 && guard < 2000) begin
			send_item(KIND_ADVANCE, 8'hFF, any_offset(), any_byte());
			guard++;
		end
		repeat (8) send_item(KIND_ADVANCE, 8'hFF, any_offset(), any_byte());
		send_item(KIND_WRITE, any_byte(), REG_CONTROL, any_byte() & ~CTRL_ENABLE);
		send_item(KIND_ADVANCE, any_byte(), any_offset(), any_byte());
	endtask

	task automatic random_traffic();
		int base;
		int pick;
		bit flood_done;
		bit pause_done;
		base = sent;
		flood_done = 1'b0;
		pause_done = 1'b0;
		while (sent - base < RANDOM_ITEMS) begin
			quiet_tail = (sent - base) >= RANDOM_ITEMS - TAIL_ITEMS;
			gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 6;
			if (!flood_done && sent - base >= 100) begin
				flood_to_saturation();
				flood_done = 1'b1;
			end else if (!pause_done && sent - base >= 250) begin
				drain_results();
				pause_done = 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					run_burst();
				else if (pick < 60)
					register_burst();
				else if (pick < 82)
					line_jump_burst();
				else if (pick < 95)
					noise_burst();
				else if (!quiet_tail)
					drain_results();
			end
		end
	endtask

	initial begin : stimulus
		board = new();
		sent = 0;
		gap_odds = 0;
		quiet_tail = 1'b0;
		long_hold_done = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_ADVANCE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		directed_checks();
		drain_results();
		random_traffic();
		drain_results();
		// Allow for anything the block might still push out after the last result.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_lcd_mode_timing_and_stat: PASS");
		else
			$display("tb_lcd_mode_timing_and_stat: FAIL");
		$finish;
	end

	// Several times the slowest correct run; a lost or stuck result ends up here.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb_lcd_mode_timing_and_stat: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/lmts_pkg.sv
src/lmts_engine.sv
src/lcd_mode_timing_and_stat.sv
tb/tb_lcd_mode_timing_and_stat.sv
